>>> hdl/text_tokenizer_stream_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text tokenizer stream
// Clocked assertions, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TEXT_TOKENIZER_STREAM_MACROS_SVH
`define TEXT_TOKENIZER_STREAM_MACROS_SVH

// property must hold at every clock edge outside reset
`define TTS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define TTS_NEVER(name, cond, msg) \
   `TTS_ASSERT(name, !(cond), msg)

`endif

>>> hdl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants, types and character classes of the text tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tts_pkg;

   localparam int LINE_CHARS = 256;
   localparam int POS_W      = $clog2(LINE_CHARS);
   localparam int MAX_TOKEN  = 255;
   localparam int LINE_W     = 20;
   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_TILDE = 8'h7E;

   typedef enum logic [1:0] {
      MODE_SKIP,
      MODE_DISCARD,
      MODE_TOKEN,
      MODE_QUOTE
   } mode_type;

   // up to two results of one request, sharing one line number
   typedef struct packed {
      logic              valid0;
      logic [7:0]        char0;
      logic              last0;
      logic              eoi0;
      logic              valid1;
      logic [7:0]        char1;
      logic              last1;
      logic              eoi1;
      logic [LINE_W-1:0] line;
   } bundle_type;

   function automatic logic is_divider(input logic [7:0] c);
      logic keep;
      keep = (c >= CH_DOT && c <= CH_NINE) || (c >= CH_UA && c <= CH_UZ) ||
             (c >= CH_LA && c <= CH_LZ) || c == CH_UNDER || c == CH_PLUS ||
             c == CH_MINUS || c == CH_TILDE || c == CH_QUOTE;
      return !keep;
   endfunction

   function automatic logic is_component(input logic [7:0] c);
      return c >= CH_BANG && c <= CH_TILDE && c != CH_HASH;
   endfunction

endpackage

>>> hdl/tts_fifo.sv
// ----------------------------------------------------------------------------
// tts_fifo
// Short queue of result bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_tokenizer_stream_macros.svh"

module tts_fifo
   import tts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output bundle_type head,
   output logic       not_empty
);

   bundle_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;

   assign full      = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TTS_NEVER(a_push_when_full, push && full && !pop, "tts_fifo: push while full")
   `TTS_NEVER(a_pop_when_empty, pop && !not_empty, "tts_fifo: pop while empty")
   `TTS_ASSERT(a_count_range, count_ff <= (FIFO_AW+1)'(FIFO_DEPTH), "tts_fifo: bad count")

endmodule

>>> hdl/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front
// Scanner: classifies each byte, tracks lines and tokens, builds results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tts_front
   import tts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic              accept,
   input  logic              kind,
   input  logic [7:0]        char_byte,
   output logic              push,
   output bundle_type        push_data
);

   typedef struct packed {
      mode_type   mode;
      logic       in_quotes;
      logic [7:0] held_char;
      logic       held_valid;
      logic [7:0] tok_len;
   } tok_state_type;

   typedef struct packed {
      tok_state_type st;
      bundle_type    b;
   } work_type;

   localparam tok_state_type TOK_IDLE = '{mode: MODE_SKIP, in_quotes: 1'b0,
      held_char: 8'h00, held_valid: 1'b0, tok_len: 8'h00};

   tok_state_type     st_ff, st_in;
   logic [7:0]        limit_ff, limit_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              acr_ff, acr_in;

   logic [7:0]        eff_lim;
   logic [POS_W-1:0]  pos_next;
   work_type          w;

   function automatic work_type put_res(input work_type wi, input logic [7:0] ch,
                                        input logic last, input logic eoi);
      work_type r;
      r = wi;
      if (!r.b.valid0) begin
         r.b.valid0 = 1'b1;
         r.b.char0  = ch;
         r.b.last0  = last;
         r.b.eoi0   = eoi;
      end else if (!r.b.valid1) begin
         r.b.valid1 = 1'b1;
         r.b.char1  = ch;
         r.b.last1  = last;
         r.b.eoi1   = eoi;
      end
      return r;
   endfunction

   function automatic work_type flush_tok(input work_type wi);
      work_type r;
      r = wi;
      if (r.st.mode == MODE_TOKEN && r.st.held_valid) begin
         r = put_res(r, r.st.held_char, 1'b1, 1'b0);
      end
      r.st = TOK_IDLE;
      return r;
   endfunction

   function automatic work_type check_lim(input work_type wi, input logic [7:0] lim);
      work_type r;
      r = wi;
      if (r.st.tok_len >= lim) begin
         r = flush_tok(r);
      end
      return r;
   endfunction

   function automatic work_type start_fresh(input work_type wi, input logic [7:0] c,
                                            input logic [7:0] lim);
      work_type r;
      r = wi;
      if (c == CH_HASH || c == CH_NUL) begin
         r.st.mode = MODE_DISCARD;
      end else if (is_component(c)) begin
         if (c == CH_QUOTE) begin
            r.st.mode    = MODE_QUOTE;
            r.st.tok_len = 8'h00;
         end else if (is_divider(c)) begin
            r = put_res(r, c, 1'b1, 1'b0);
         end else begin
            r.st.held_char  = c;
            r.st.held_valid = 1'b1;
            r.st.tok_len    = 8'h01;
            r.st.in_quotes  = 1'b0;
            r.st.mode       = MODE_TOKEN;
            r = check_lim(r, lim);
         end
      end
      return r;
   endfunction

   always_comb begin
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
      eff_lim  = (limit_ff > 8'(MAX_TOKEN)) ? 8'(MAX_TOKEN) : limit_ff;
      pos_next = pos_ff + 1'b1;
      w        = '{st: st_ff, b: '0};
      line_in  = line_ff;
      pos_in   = pos_ff;
      acr_in   = acr_ff;
      if (accept) begin
         if (kind) begin
            w      = flush_tok(w);
            w      = put_res(w, 8'h00, 1'b0, 1'b1);
            pos_in = '0;
            acr_in = 1'b0;
         end else if (acr_ff && char_byte == CH_LF) begin
            acr_in = 1'b0;
         end else begin
            acr_in = 1'b0;
            if (pos_ff == '0 && line_ff != LINE_MAX) begin
               line_in = line_ff + 1'b1;
            end
            if (char_byte == CH_CR || char_byte == CH_LF) begin
               w      = flush_tok(w);
               pos_in = '0;
               acr_in = (char_byte == CH_CR);
            end else begin
               case (w.st.mode)
                  MODE_SKIP: begin
                     w = start_fresh(w, char_byte, eff_lim);
                  end
                  MODE_QUOTE: begin
                     w.st.tok_len = 8'h01;
                     if (is_divider(char_byte)) begin
                        w = put_res(w, char_byte, 1'b1, 1'b0);
                        w = flush_tok(w);
                     end else begin
                        w.st.held_char  = char_byte;
                        w.st.held_valid = 1'b1;
                        w.st.in_quotes  = 1'b1;
                        w.st.mode       = MODE_TOKEN;
                        w = check_lim(w, eff_lim);
                     end
                  end
                  MODE_TOKEN: begin
                     if (!w.st.in_quotes && is_divider(char_byte)) begin
                        w = flush_tok(w);
                        w = start_fresh(w, char_byte, eff_lim);
                     end else begin
                        if (w.st.tok_len != 8'hFF) begin
                           w.st.tok_len = w.st.tok_len + 8'h01;
                        end
                        if (char_byte == CH_QUOTE) begin
                           w.st.in_quotes = 1'b0;
                        end else begin
                           if (w.st.held_valid) begin
                              w = put_res(w, w.st.held_char, 1'b0, 1'b0);
                           end
                           w.st.held_char  = char_byte;
                           w.st.held_valid = 1'b1;
                        end
                        w = check_lim(w, eff_lim);
                     end
                  end
                  default: begin
                  end
               endcase
               if (pos_next >= POS_W'(LINE_CHARS - 1)) begin
                  pos_in = '0;
                  w      = flush_tok(w);
               end else begin
                  pos_in = pos_next;
               end
            end
         end
      end
      st_in          = w.st;
      push_data      = w.b;
      push_data.line = line_in;
      push           = accept && w.b.valid0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= TOK_IDLE;
         limit_ff <= 8'd32;
         line_ff  <= '0;
         pos_ff   <= '0;
         acr_ff   <= 1'b0;
      end else begin
         st_ff    <= st_in;
         limit_ff <= limit_in;
         line_ff  <= line_in;
         pos_ff   <= pos_in;
         acr_ff   <= acr_in;
      end
   end

endmodule

>>> hdl/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back
// Output stage: takes bundles from the queue and sends one result a cycle while rsp_tready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_tokenizer_stream_macros.svh"

module tts_back
   import tts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  bundle_type        head,
   input  logic              not_empty,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        token_char,
   output logic              last_of_token,
   output logic [LINE_W-1:0] line_number,
   output logic              end_of_input
);

   bundle_type cur_ff, cur_in;
   logic       have_ff, have_in;
   logic       idx_ff, idx_in;
   logic       done;

   always_comb begin
      done    = rsp_tready && (idx_ff || !cur_ff.valid1);
      pop     = not_empty && (!have_ff || done);
      cur_in  = pop ? head : cur_ff;
      have_in = have_ff;
      idx_in  = idx_ff;
      if (pop) begin
         have_in = 1'b1;
         idx_in  = 1'b0;
      end else if (have_ff && rsp_tready) begin
         if (done) begin
            have_in = 1'b0;
            idx_in  = 1'b0;
         end else begin
            idx_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         idx_ff  <= 1'b0;
      end else begin
         have_ff <= have_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_tvalid    = have_ff;
   assign token_char    = idx_ff ? cur_ff.char1 : cur_ff.char0;
   assign last_of_token = idx_ff ? cur_ff.last1 : cur_ff.last0;
   assign end_of_input  = idx_ff ? cur_ff.eoi1  : cur_ff.eoi0;
   assign line_number   = cur_ff.line;

   `TTS_NEVER(a_second_valid, have_ff && idx_ff && !cur_ff.valid1, "tts_back: empty slot sent")
   `TTS_NEVER(a_idx_idle, !have_ff && idx_ff, "tts_back: slot index set while idle")
   `TTS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> $stable(cur_ff), "tts_back: stall")

endmodule

>>> hdl/text_tokenizer_stream.sv
// ----------------------------------------------------------------------------
// text_tokenizer_stream
// Byte stream tokenizer: one request per byte, one response per token char.
// ----------------------------------------------------------------------------
// Requests: req_tdata[7:0] is a byte, req_tuser set marks end of input.
// Responses: one per token character, rsp_tlast on the final character of
// a token, rsp_tdata[27:8] the line number; rsp_tuser marks the end-of-input
// response that follows any flushed token.
// csr_wr_en / csr_wr_data set the token length limit (reset value 32);
// write it only while the block is idle.
// The first response of a request passes through the queue and then the
// output register before it can be accepted.
// Throughput: one request per cycle unless the queue is full; a request may
// cause up to two responses, which leave the output register one per cycle while rsp_tready is high.
// The scanner feeds a four-entry queue of response pairs; req_tready drops
// only when that queue is full, so a stalled receiver backs up into it.
// Reset clears scanner state, line count, queue and output stage and
// restores the limit register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_tokenizer_stream
   import tts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] token_char, [27:8] line_number, pad
   output logic        rsp_tlast,   // last_of_token
   output logic        rsp_tuser    // [0] end_of_input
);

   logic              accept;
   logic              push, pop, full, not_empty;
   bundle_type        push_data, head;
   logic [7:0]        token_char;
   logic [LINE_W-1:0] line_number;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   tts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .kind        (req_tuser),
      .char_byte   (req_tdata),
      .push        (push),
      .push_data   (push_data)
   );

   tts_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty)
   );

   tts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .not_empty     (not_empty),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .token_char    (token_char),
      .last_of_token (rsp_tlast),
      .line_number   (line_number),
      .end_of_input  (rsp_tuser)
   );

   assign rsp_tdata = {4'h0, line_number, token_char};

endmodule
